FILE: hdl/fac_pkg.sv
// ---------------------------------------------------------------------------
// fac_pkg: shared types and constants for the frustum box cull block
// Field widths, plane register indexes and fixed-point helpers.
// ---------------------------------------------------------------------------
package fac_pkg;

   localparam int CoordW  = 16;
   localparam int WordW   = 64;
   localparam int NumPlanes = 6;
   localparam int FracShift = 14;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic [WordW-1:0]         word_type;
   typedef logic [2:0]               csr_idx_type;

   localparam csr_idx_type CsrPlaneLeft   = 3'd0;
   localparam csr_idx_type CsrPlaneRight  = 3'd1;
   localparam csr_idx_type CsrPlaneBottom = 3'd2;
   localparam csr_idx_type CsrPlaneTop    = 3'd3;
   localparam csr_idx_type CsrPlaneNear   = 3'd4;
   localparam csr_idx_type CsrPlaneFar    = 3'd5;

   // extract signed 16-bit lane k of a packed word
   function automatic coord_type lane16(input word_type w, input int k);
      lane16 = coord_type'(w[16*k +: 16]);
   endfunction

   // round Q.18 to Q.4 (nearest, ties up), then saturate to 16 bits
   function automatic coord_type round_sat(input logic signed [35:0] v);
      logic signed [35:0] b;
      logic signed [21:0] r;
      b = v + 36'sd8192;
      r = b[35:14];
      if (r > 22'sd32767)       round_sat = 16'sh7fff;
      else if (r < -22'sd32768) round_sat = 16'sh8000;
      else                      round_sat = r[15:0];
   endfunction

endpackage

FILE: hdl/frustum_aabb_cull.sv
// ---------------------------------------------------------------------------
// frustum_aabb_cull: world-space box and six-plane visibility test
// Transforms eight local box corners, takes the world min/max box and runs
// the positive-vertex test against six configured planes.
// ---------------------------------------------------------------------------
// A new beat is taken every cycle (busy is tied low). Each result passes
// through the stages below and appears for one cycle, flagged by rsp_valid:
// stage 1 products, stage 2 corner sums with rounding, stage 3 min/max,
// stage 4 plane products, stage 5 plane sums and the sign test. The
// receiver cannot stall. Write planes only while no beat is in flight.
module frustum_aabb_cull (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fac_pkg::word_type    req_mat_row_x,
   input  fac_pkg::word_type    req_mat_row_y,
   input  fac_pkg::word_type    req_mat_row_z,
   input  fac_pkg::coord_type   req_local_min_x,
   input  fac_pkg::coord_type   req_local_min_y,
   input  fac_pkg::coord_type   req_local_min_z,
   input  fac_pkg::coord_type   req_local_max_x,
   input  fac_pkg::coord_type   req_local_max_y,
   input  fac_pkg::coord_type   req_local_max_z,
   output logic                 rsp_valid,
   output logic                 rsp_visible,
   output fac_pkg::coord_type   rsp_world_min_x,
   output fac_pkg::coord_type   rsp_world_min_y,
   output fac_pkg::coord_type   rsp_world_min_z,
   output fac_pkg::coord_type   rsp_world_max_x,
   output fac_pkg::coord_type   rsp_world_max_y,
   output fac_pkg::coord_type   rsp_world_max_z,
   input  logic                 csr_we,
   input  fac_pkg::csr_idx_type csr_idx,
   input  fac_pkg::word_type    csr_wdata
);
   import fac_pkg::*;

   assign busy = 1'b0;

   // plane registers
   word_type plane_ff [NumPlanes];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NumPlanes; p++) plane_ff[p] <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CsrPlaneLeft:   plane_ff[0] <= csr_wdata;
            CsrPlaneRight:  plane_ff[1] <= csr_wdata;
            CsrPlaneBottom: plane_ff[2] <= csr_wdata;
            CsrPlaneTop:    plane_ff[3] <= csr_wdata;
            CsrPlaneNear:   plane_ff[4] <= csr_wdata;
            CsrPlaneFar:    plane_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [4:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[3:0], start};
   end

   // stage 1: products m*coord for every row, axis and end (lo/hi)
   // prod[row][axis][end]; translation kept apart
   logic signed [31:0] prod_ff [3][3][2];
   logic signed [31:0] prod_in [3][3][2];
   coord_type          tr_ff [3];
   word_type           rows [3];
   coord_type          lo [3], hi [3];
   always_comb begin
      rows[0] = req_mat_row_x; rows[1] = req_mat_row_y; rows[2] = req_mat_row_z;
      lo[0] = req_local_min_x; lo[1] = req_local_min_y; lo[2] = req_local_min_z;
      hi[0] = req_local_max_x; hi[1] = req_local_max_y; hi[2] = req_local_max_z;
      for (int r = 0; r < 3; r++)
         for (int a = 0; a < 3; a++) begin
            prod_in[r][a][0] = lane16(rows[r], a) * lo[a];
            prod_in[r][a][1] = lane16(rows[r], a) * hi[a];
         end
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      for (int r = 0; r < 3; r++) tr_ff[r] <= lane16(rows[r], 3);
   end

   // stage 2: eight corner sums per row, rounded and saturated
   coord_type corner_ff [3][8];
   coord_type corner_in [3][8];
   always_comb begin
      logic signed [35:0] s;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 8; c++) begin
            s = 36'(prod_ff[r][0][c & 1]) + 36'(prod_ff[r][1][(c >> 1) & 1])
              + 36'(prod_ff[r][2][(c >> 2) & 1]) + (36'(tr_ff[r]) <<< FracShift);
            corner_in[r][c] = round_sat(s);
         end
   end
   always_ff @(posedge clock) corner_ff <= corner_in;

   // stage 3: min/max over corners
   coord_type wmin_ff [3], wmax_ff [3];
   coord_type wmin_in [3], wmax_in [3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         wmin_in[r] = corner_ff[r][0];
         wmax_in[r] = corner_ff[r][0];
         for (int c = 1; c < 8; c++) begin
            if (corner_ff[r][c] < wmin_in[r]) wmin_in[r] = corner_ff[r][c];
            if (corner_ff[r][c] > wmax_in[r]) wmax_in[r] = corner_ff[r][c];
         end
      end
   end
   always_ff @(posedge clock) begin
      wmin_ff <= wmin_in;
      wmax_ff <= wmax_in;
   end

   // stage 4: plane products against the positive vertex
   logic signed [31:0] pp_ff [NumPlanes][3];
   coord_type          pd_ff [NumPlanes];
   coord_type          wmin4_ff [3], wmax4_ff [3];
   always_ff @(posedge clock) begin
      for (int p = 0; p < NumPlanes; p++) begin
         for (int a = 0; a < 3; a++)
            pp_ff[p][a] <= lane16(plane_ff[p], a) *
               (lane16(plane_ff[p], a) >= 0 ? wmax_ff[a] : wmin_ff[a]);
         pd_ff[p] <= lane16(plane_ff[p], 3);
      end
      wmin4_ff <= wmin_ff;
      wmax4_ff <= wmax_ff;
   end

   // stage 5: distance sign per plane
   logic vis_in;
   always_comb begin
      logic signed [35:0] d;
      vis_in = 1'b1;
      for (int p = 0; p < NumPlanes; p++) begin
         d = 36'(pp_ff[p][0]) + 36'(pp_ff[p][1]) + 36'(pp_ff[p][2])
           + (36'(pd_ff[p]) <<< FracShift);
         if (d[35]) vis_in = 1'b0;
      end
   end
   logic      vis_ff;
   coord_type omin_ff [3], omax_ff [3];
   always_ff @(posedge clock) begin
      vis_ff  <= vis_in;
      omin_ff <= wmin4_ff;
      omax_ff <= wmax4_ff;
   end

   assign rsp_valid       = vld_ff[4];
   assign rsp_visible     = vis_ff;
   assign rsp_world_min_x = omin_ff[0];
   assign rsp_world_min_y = omin_ff[1];
   assign rsp_world_min_z = omin_ff[2];
   assign rsp_world_max_x = omax_ff[0];
   assign rsp_world_max_y = omax_ff[1];
   assign rsp_world_max_z = omax_ff[2];

endmodule
